/* hdl/fcw_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcw_pkg: shared types and constants of the cluster chain walker
// Table geometry, FAT kind codes, end-of-chain limits, transfer payloads
// and the control bundle of the shared arithmetic unit.
// ----------------------------------------------------------------------------
package fcw_pkg;

    localparam int TABLE_ENTRIES = 4096;
    localparam int MAX_RUN       = 63;
    localparam int TBL_AW        = $clog2(TABLE_ENTRIES);
    localparam int STEP_W        = TBL_AW + 1;

    localparam int CLUSTER_W = 32;
    localparam int SPC_W     = 8;
    localparam int COUNT_W   = 6;
    localparam int INDEX_W   = 12;
    localparam int CFG_AW    = 2;
    localparam int CFG_DW    = 32;

    localparam logic [CLUSTER_W-1:0] ALL_ONES      = '1;
    localparam logic [CLUSTER_W-1:0] FIRST_CLUSTER = 32'd2;
    localparam logic [CLUSTER_W-1:0] TABLE_END     = CLUSTER_W'(TABLE_ENTRIES);

    localparam logic [1:0] FAT_12   = 2'd0;
    localparam logic [1:0] FAT_16   = 2'd1;
    localparam logic [1:0] FAT_32   = 2'd2;
    localparam logic [1:0] FAT_NONE = 2'd3;

    localparam logic [CLUSTER_W-1:0] LIMIT_FAT12 = 32'h0000_0FF7;
    localparam logic [CLUSTER_W-1:0] LIMIT_FAT16 = 32'h0000_FFF7;
    localparam logic [CLUSTER_W-1:0] LIMIT_FAT32 = 32'h0FFF_FFF7;

    localparam logic [CFG_AW-1:0] CFG_FAT_KIND = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_SPC      = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_FDS      = 2'd2;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_WALK = 1'b1;

    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    typedef struct packed {
        logic                 mode;
        logic [INDEX_W-1:0]   entry_index;
        logic [CLUSTER_W-1:0] entry_value;
        logic [CLUSTER_W-1:0] head_cluster;
        logic [CLUSTER_W-1:0] skip_count;
        logic [COUNT_W-1:0]   cluster_count;
    } t_in_item;

    typedef struct packed {
        logic                 kind;
        logic [CLUSTER_W-1:0] cluster;
        logic [CLUSTER_W-1:0] first_block;
        logic [SPC_W-1:0]     block_count;
        logic                 out_of_range;
        logic                 last;
    } t_out_item;

    typedef enum logic {
        ALU_MUL,
        ALU_MOD
    } t_alu_op;

    typedef struct packed {
        logic    start;
        t_alu_op op;
    } t_alu_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_alu_rsp;

    function automatic logic [CLUSTER_W-1:0] fat_limit(input logic [1:0] kind);
        logic [CLUSTER_W-1:0] lim;
        case (kind)
            FAT_12:  lim = LIMIT_FAT12;
            FAT_16:  lim = LIMIT_FAT16;
            default: lim = LIMIT_FAT32;
        endcase
        return lim;
    endfunction

endpackage

/* hdl/fat_cluster_chain_walker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fat_cluster_chain_walker: FAT cluster chain traversal engine
// Holds the decoded allocation table in RAM, follows a chain one lookup
// at a time and issues one read request per cluster past the skipped ones.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                    payload
//  in        input      i_in_valid / o_in_stall      i_in_data  (t_in_item)
//  out       output     o_out_valid / i_out_stall    o_out_data (t_out_item)
//  cfg       input      i_cfg_we                     i_cfg_addr, i_cfg_wdata
//
//  A load item writes one table entry and leaves the block idle. A walk
//  steps through the skipped clusters by registered table lookups, then forms
//  each read's first block on the 8-step shared multiplier. After TABLE_ENTRIES
//  skip steps a loop in the chain is measured and the skip folded by a
//  remainder on the same unit. No clearing pass after reset; table entries
//  are undefined until loaded. A stalled result holds the walk in place.
// ----------------------------------------------------------------------------
module fat_cluster_chain_walker
    import fcw_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_item          i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_item         o_out_data,
    input  logic              i_cfg_we,
    input  logic [CFG_AW-1:0] i_cfg_addr,
    input  logic [CFG_DW-1:0] i_cfg_wdata
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_STEP,
        S_MUL,
        S_EMIT,
        S_LOOK,
        S_LWAIT,
        S_CYC,
        S_CWAIT,
        S_MOD,
        S_DONE
    } t_state;

    t_state               r_state,    n_state;
    logic [1:0]           r_kind,     n_kind;
    logic [SPC_W-1:0]     r_spc,      n_spc;
    logic [CLUSTER_W-1:0] r_fds,      n_fds;
    logic [CLUSTER_W-1:0] r_cur,      n_cur;
    logic [CLUSTER_W-1:0] r_skip,     n_skip;
    logic [COUNT_W-1:0]   r_cap,      n_cap;
    logic [COUNT_W-1:0]   r_reads,    n_reads;
    logic [STEP_W-1:0]    r_steps,    n_steps;
    logic                 r_reduced,  n_reduced;
    logic                 r_oor,      n_oor;
    logic [TBL_AW-1:0]    r_c0,       n_c0;
    logic [CLUSTER_W-1:0] r_t,        n_t;
    logic [STEP_W-1:0]    r_len,      n_len;
    logic                 r_out_valid, n_out_valid;
    t_out_item            r_out_data,  n_out_data;

    logic                 out_free;
    logic                 ram_we;
    logic                 ram_re;
    logic [TBL_AW-1:0]    ram_raddr;
    logic [CLUSTER_W-1:0] ram_rdata;
    logic [CLUSTER_W-1:0] rd_next;
    logic [STEP_W-1:0]    step_inc;
    logic [STEP_W-1:0]    len_inc;
    t_alu_req             alu_req;
    t_alu_rsp             alu_rsp;
    logic [CLUSTER_W-1:0] alu_opa;
    logic [CLUSTER_W-1:0] alu_opb;
    logic [CLUSTER_W-1:0] alu_result;

    fcw_ram #(
        .WIDTH (CLUSTER_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (TBL_AW'(i_in_data.entry_index)),
        .i_wdata (i_in_data.entry_value),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    fcw_alu u_alu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (alu_req),
        .i_opa    (alu_opa),
        .i_opb    (alu_opb),
        .i_addend (r_fds),
        .o_rsp    (alu_rsp),
        .o_result (alu_result)
    );

    assign alu_opa = (alu_req.op == ALU_MUL) ? (r_cur - FIRST_CLUSTER) : r_skip;
    assign alu_opb = (alu_req.op == ALU_MUL) ? CLUSTER_W'(r_spc) : CLUSTER_W'(len_inc);

    assign out_free = !r_out_valid || !i_out_stall;
    assign rd_next  = (ram_rdata >= fat_limit(r_kind)) ? ALL_ONES : ram_rdata;
    assign step_inc = r_steps + 1'b1;
    assign len_inc  = r_len + 1'b1;

    always_comb begin
        n_state     = r_state;
        n_kind      = r_kind;
        n_spc       = r_spc;
        n_fds       = r_fds;
        n_cur       = r_cur;
        n_skip      = r_skip;
        n_cap       = r_cap;
        n_reads     = r_reads;
        n_steps     = r_steps;
        n_reduced   = r_reduced;
        n_oor       = r_oor;
        n_c0        = r_c0;
        n_t         = r_t;
        n_len       = r_len;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_data  = r_out_data;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_raddr   = r_cur[TBL_AW-1:0];
        alu_req     = '{start: 1'b0, op: ALU_MUL};

        if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_FAT_KIND: n_kind = i_cfg_wdata[1:0];
                CFG_SPC:      n_spc  = i_cfg_wdata[SPC_W-1:0];
                CFG_FDS:      n_fds  = i_cfg_wdata;
                default:      ;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_data.mode == MODE_LOAD) begin
                        ram_we = CLUSTER_W'(i_in_data.entry_index) < TABLE_END;
                    end else begin
                        n_cur     = i_in_data.head_cluster;
                        n_skip    = i_in_data.skip_count;
                        n_cap     = (i_in_data.cluster_count > COUNT_W'(MAX_RUN)) ?
                                    COUNT_W'(MAX_RUN) : i_in_data.cluster_count;
                        n_reads   = '0;
                        n_steps   = '0;
                        n_reduced = 1'b0;
                        n_oor     = 1'b0;
                        n_state   = S_STEP;
                    end
                end
            end
            S_STEP: begin
                if (r_skip != '0) begin
                    n_skip  = r_skip - 1'b1;
                    n_state = S_LOOK;
                end else begin
                    alu_req = '{start: 1'b1, op: ALU_MUL};
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                if (alu_rsp.done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = '{kind: KIND_READ, cluster: r_cur,
                                    first_block: alu_result, block_count: r_spc,
                                    out_of_range: 1'b0, last: 1'b0};
                    n_reads     = r_reads + 1'b1;
                    n_state     = S_LOOK;
                end
            end
            S_LOOK: begin
                if (r_kind == FAT_NONE) begin
                    n_cur   = ALL_ONES;
                    n_state = S_DONE;
                end else if (r_cur >= TABLE_END) begin
                    n_oor   = 1'b1;
                    n_state = S_DONE;
                end else begin
                    ram_re  = 1'b1;
                    n_state = S_LWAIT;
                end
            end
            S_LWAIT: begin
                n_cur = rd_next;
                if (rd_next == ALL_ONES || r_reads >= r_cap) begin
                    n_state = S_DONE;
                end else if (!r_reduced && r_skip != '0) begin
                    n_steps = step_inc;
                    if (step_inc >= STEP_W'(TABLE_ENTRIES) && rd_next < TABLE_END) begin
                        n_c0    = rd_next[TBL_AW-1:0];
                        n_t     = rd_next;
                        n_len   = '0;
                        n_state = S_CYC;
                    end else begin
                        n_state = S_STEP;
                    end
                end else begin
                    n_state = S_STEP;
                end
            end
            S_CYC: begin
                if (r_t >= TABLE_END) begin
                    n_reduced = 1'b1;
                    n_state   = S_STEP;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = r_t[TBL_AW-1:0];
                    n_state   = S_CWAIT;
                end
            end
            S_CWAIT: begin
                n_len = len_inc;
                if (rd_next == CLUSTER_W'(r_c0)) begin
                    alu_req = '{start: 1'b1, op: ALU_MOD};
                    n_state = S_MOD;
                end else if (len_inc >= STEP_W'(TABLE_ENTRIES) || rd_next == ALL_ONES) begin
                    n_reduced = 1'b1;
                    n_state   = S_STEP;
                end else begin
                    n_t     = rd_next;
                    n_state = S_CYC;
                end
            end
            S_MOD: begin
                if (alu_rsp.done) begin
                    n_skip    = alu_result;
                    n_reduced = 1'b1;
                    n_state   = S_STEP;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = '{kind: KIND_DONE, cluster: r_cur,
                                    first_block: '0, block_count: '0,
                                    out_of_range: r_oor, last: 1'b1};
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_cur      <= n_cur;
        r_skip     <= n_skip;
        r_cap      <= n_cap;
        r_reads    <= n_reads;
        r_steps    <= n_steps;
        r_reduced  <= n_reduced;
        r_oor      <= n_oor;
        r_c0       <= n_c0;
        r_t        <= n_t;
        r_len      <= n_len;
        r_out_data <= n_out_data;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_kind      <= FAT_16;
            r_spc       <= SPC_W'(1);
            r_fds       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_kind      <= n_kind;
            r_spc       <= n_spc;
            r_fds       <= n_fds;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

/* hdl/fcw_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcw_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module fcw_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/fcw_alu.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcw_alu: shared iterative shift-add / shift-subtract unit
// Multiply-accumulate (a * b[7:0] + addend) in 8 steps, or remainder
// (a mod b) in 32 restoring steps, both through one adder.
// ----------------------------------------------------------------------------
module fcw_alu
    import fcw_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_alu_req             i_req,
    input  logic [CLUSTER_W-1:0] i_opa,
    input  logic [CLUSTER_W-1:0] i_opb,
    input  logic [CLUSTER_W-1:0] i_addend,
    output t_alu_rsp             o_rsp,
    output logic [CLUSTER_W-1:0] o_result
);

    localparam int MUL_STEPS = SPC_W;
    localparam int MOD_STEPS = CLUSTER_W;
    localparam int CNT_W     = $clog2(MOD_STEPS);

    t_alu_op              r_op,   n_op;
    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [CNT_W-1:0]     r_cnt,  n_cnt;
    logic [CLUSTER_W-1:0] r_acc,  n_acc;
    logic [CLUSTER_W-1:0] r_x,    n_x;
    logic [CLUSTER_W-1:0] r_y,    n_y;

    logic [CLUSTER_W+1:0] add_a;
    logic [CLUSTER_W+1:0] add_b;
    logic                 add_cin;
    logic [CLUSTER_W+1:0] sum;

    always_comb begin
        if (r_op == ALU_MUL) begin
            add_a   = {2'b00, r_acc};
            add_b   = {2'b00, (r_y[0] ? r_x : '0)};
            add_cin = 1'b0;
        end else begin
            add_a   = {1'b0, r_acc, r_x[CLUSTER_W-1]};
            add_b   = {1'b0, ~{1'b0, r_y}};
            add_cin = 1'b1;
        end
        sum = add_a + add_b + (CLUSTER_W+2)'(add_cin);
    end

    always_comb begin
        n_op   = r_op;
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_acc  = r_acc;
        n_x    = r_x;
        n_y    = r_y;
        if (i_req.start) begin
            n_op   = i_req.op;
            n_busy = 1'b1;
            n_x    = i_opa;
            n_y    = i_opb;
            if (i_req.op == ALU_MUL) begin
                n_acc = i_addend;
                n_cnt = CNT_W'(MUL_STEPS - 1);
            end else begin
                n_acc = '0;
                n_cnt = CNT_W'(MOD_STEPS - 1);
            end
        end else if (r_busy) begin
            if (r_op == ALU_MUL) begin
                n_acc = sum[CLUSTER_W-1:0];
                n_x   = {r_x[CLUSTER_W-2:0], 1'b0};
                n_y   = {1'b0, r_y[CLUSTER_W-1:1]};
            end else begin
                n_acc = sum[CLUSTER_W+1] ? sum[CLUSTER_W-1:0] : add_a[CLUSTER_W-1:0];
                n_x   = {r_x[CLUSTER_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op  <= n_op;
        r_cnt <= n_cnt;
        r_acc <= n_acc;
        r_x   <= n_x;
        r_y   <= n_y;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_result   = r_acc;

endmodule

/* hdl/fcw_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcw_checker: port-level checks for the cluster chain walker
// Watches both transfer channels and the result framing.
// ----------------------------------------------------------------------------
module fcw_checker
    import fcw_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input t_in_item          i_in_data,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input t_out_item         o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_data))
        else $error("stalled result changed");

    a_walk_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_in_data.mode == MODE_WALK |=> o_in_stall)
        else $error("walk transfer did not occupy the block");

    a_read_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.kind == KIND_READ
            |-> !o_out_data.last && !o_out_data.out_of_range)
        else $error("read request carries completion flags");

    a_done_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.kind == KIND_DONE
            |-> o_out_data.last && o_out_data.first_block == '0
                && o_out_data.block_count == '0)
        else $error("completion carries read fields");

endmodule

bind fat_cluster_chain_walker fcw_checker u_fcw_checker (.*);
